[rtl/itws_pkg.sv]
// ----------------------------------------------------------------------------
// Interpolated table waveshaper package
// Shared defaults, request codes and the result queue status type.
// ----------------------------------------------------------------------------
package itws_pkg;

  // Default geometry: 512 table intervals, Q3.20 samples.
  localparam int unsigned INTERVALS_DEF     = 512;
  localparam int unsigned SAMPLE_WIDTH_DEF  = 24;
  localparam int unsigned FRACTION_BITS_DEF = 20;

  // Depth of the result queue; it also bounds the shape requests in flight.
  localparam int unsigned RESULT_DEPTH_DEF  = 8;

  // Request codes carried by req_type.
  typedef enum logic {
    ReqShape = 1'b0,
    ReqWrite = 1'b1
  } req_type_e;

  // Status of the result queue, seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[rtl/itws_if.sv]
// ----------------------------------------------------------------------------
// Interpolated table waveshaper channels
// Request and result channels with valid/ready flow control.
// ----------------------------------------------------------------------------
interface itws_in_if #(
  parameter int unsigned SampleWidth = itws_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned IndexWidth  = $clog2(itws_pkg::INTERVALS_DEF + 1)
);
  import itws_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [SampleWidth-1:0] sample_in;
  logic        [IndexWidth-1:0]  entry_index;
  logic signed [SampleWidth-1:0] entry_value;

  modport source (
    output valid, req_type, sample_in, entry_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, sample_in, entry_index, entry_value,
    output ready
  );
endinterface

interface itws_out_if #(
  parameter int unsigned SampleWidth = itws_pkg::SAMPLE_WIDTH_DEF
);
  import itws_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] shaped_sample;
  logic                          clipped;

  modport source (
    output valid, shaped_sample, clipped,
    input  ready
  );
  modport sink (
    input  valid, shaped_sample, clipped,
    output ready
  );
endinterface

[rtl/itws_result_fifo.sv]
// ----------------------------------------------------------------------------
// Interpolated table waveshaper result queue
// Small register FIFO that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
module itws_result_fifo #(
  parameter int unsigned Width = 25,
  parameter int unsigned Depth = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [Width-1:0]       push_data_i,
  input  logic                   pop_i,
  output logic [Width-1:0]       pop_data_o,
  output itws_pkg::fifo_status_t status_o
);
  import itws_pkg::*;

  localparam int unsigned PtrWidth = $clog2(Depth);
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    entries_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign do_push = push_i && (count_q != CntWidth'(Depth));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrWidth'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrWidth'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntWidth'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntWidth'(Depth));
  assign status_o.empty = (count_q == '0);

endmodule

[rtl/interpolated_table_waveshaper_unit.sv]
// ----------------------------------------------------------------------------
// Interpolated table waveshaper
// Maps samples through a transfer table with linear interpolation between
// neighbouring entries; table entries are loaded through the same channel.
// ----------------------------------------------------------------------------
//
//   channel  direction  contents
//   -------  ---------  ---------------------------------------------------
//   in_i     sink       req_type, sample_in, entry_index, entry_value
//   out_o    source     shaped_sample, clipped (one per shape request)
//
// One request is taken per cycle while in_i.ready is high. A shape request
// passes the request, memory, read and sum registers before it enters the
// result queue, from which its result can leave. The table memory serves one
// write or one pair of reads per cycle, in request order, so a read always sees every earlier write.
// Reset clears the pipeline valid flags and the result queue, not the table.
// Once RESULT_DEPTH_DEF shape requests are in flight, in_i.ready falls.
//
module interpolated_table_waveshaper_unit #(
  parameter int unsigned INTERVALS     = itws_pkg::INTERVALS_DEF,
  parameter int unsigned SAMPLE_WIDTH  = itws_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = itws_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itws_in_if.sink   in_i,
  itws_out_if.source out_o
);
  import itws_pkg::*;

  // Widths derived from the geometry.
  localparam int unsigned SW       = SAMPLE_WIDTH;
  localparam int unsigned FB       = FRACTION_BITS;
  localparam int unsigned IW       = $clog2(INTERVALS + 1);
  localparam int unsigned PW       = SW + IW;          // position width
  localparam int unsigned XW       = PW - FB;          // integer index width
  localparam int unsigned DW       = SW + 1;           // entry difference
  localparam int unsigned MW       = DW + FB + 1;      // interpolation product
  localparam int unsigned Depth    = RESULT_DEPTH_DEF;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  localparam logic [SW:0]   Half     = (SW + 1)'(1) << (FB - 1);
  localparam logic [PW-1:0] SizePos  = PW'(INTERVALS);
  localparam logic [XW-1:0] SizeIdx  = XW'(INTERVALS);
  localparam logic [IW-1:0] LastAddr = IW'(INTERVALS);

  // --------------------------------------------------------------------------
  // Request stage: the accepted transfer is registered as it arrives.
  // --------------------------------------------------------------------------
  logic                 in_xfer;
  logic                 out_xfer;
  logic [CntWidth-1:0]  inflight_q, inflight_d;

  logic                 p_valid_q;
  logic                 p_write_q;
  logic signed [SW-1:0] p_sample_q;
  logic [IW-1:0]        p_index_q;
  logic [SW-1:0]        p_value_q;

  assign in_i.ready = (inflight_q < CntWidth'(Depth));
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;

  // Shape requests count from their transfer until their result is taken.
  always_comb begin
    inflight_d = inflight_q;
    if (in_xfer && (in_i.req_type == ReqShape) && !out_xfer) begin
      inflight_d = inflight_q + CntWidth'(1);
    end else if (out_xfer && !(in_xfer && (in_i.req_type == ReqShape))) begin
      inflight_d = inflight_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      p_valid_q  <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      p_valid_q  <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      p_write_q  <= (in_i.req_type == ReqWrite);
      p_sample_q <= in_i.sample_in;
      p_index_q  <= in_i.entry_index;
      p_value_q  <= in_i.entry_value;
    end
  end

  // Offset by one half and scale by the table size. A negative offset sample
  // lies below the table span; its position is never used.
  logic signed [SW:0] shifted;
  logic [PW-1:0]      position;

  assign shifted  = $signed({p_sample_q[SW-1], p_sample_q}) + $signed(Half);
  assign position = PW'(shifted[SW-1:0]) * SizePos;

  // --------------------------------------------------------------------------
  // Memory stage: one write, or the pair of entries around the position.
  // --------------------------------------------------------------------------
  logic          m_valid_q;
  logic          m_write_q;
  logic          m_below_q;
  logic [PW-1:0] m_pos_q;
  logic [IW-1:0] m_index_q;
  logic [SW-1:0] m_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_write_q <= p_write_q;
    m_below_q <= shifted[SW];
    m_pos_q   <= position;
    m_index_q <= p_index_q;
    m_value_q <= p_value_q;
  end

  logic [XW-1:0] m_int;
  logic          m_above;
  logic          m_clip;
  logic [IW-1:0] rd_addr_a;
  logic [IW-1:0] rd_addr_b;
  logic [FB-1:0] m_frac;
  logic          wr_en;

  // Clipped samples read the end entry at both ports with a zero fraction,
  // so the interpolation below returns that entry unchanged.
  assign m_int   = m_pos_q[PW-1:FB];
  assign m_above = (m_int >= SizeIdx);
  assign m_clip  = m_below_q || m_above;

  always_comb begin
    if (m_below_q) begin
      rd_addr_a = '0;
      rd_addr_b = '0;
    end else if (m_above) begin
      rd_addr_a = LastAddr;
      rd_addr_b = LastAddr;
    end else begin
      rd_addr_a = m_int[IW-1:0];
      rd_addr_b = m_int[IW-1:0] + IW'(1);
    end
  end

  assign m_frac = m_clip ? '0 : m_pos_q[FB-1:0];

  // Writes beyond the last entry are dropped.
  assign wr_en = m_valid_q && m_write_q && (m_index_q <= LastAddr);

  logic [SW-1:0] table_mem [INTERVALS + 1];
  logic [SW-1:0] rd_a_q;
  logic [SW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[m_index_q] <= m_value_q;
    end
    rd_a_q <= table_mem[rd_addr_a];
    rd_b_q <= table_mem[rd_addr_b];
  end

  // --------------------------------------------------------------------------
  // Read stage: weight the difference of the two entries by the fraction.
  // --------------------------------------------------------------------------
  logic          r_valid_q;
  logic          r_clip_q;
  logic [FB-1:0] r_frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= m_valid_q && !m_write_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_clip_q <= m_clip;
    r_frac_q <= m_frac;
  end

  logic signed [DW-1:0] diff;
  logic signed [MW-1:0] product;

  assign diff    = $signed({rd_b_q[SW-1], rd_b_q}) - $signed({rd_a_q[SW-1], rd_a_q});
  assign product = MW'(diff) * $signed({1'b0, r_frac_q});

  // --------------------------------------------------------------------------
  // Sum stage: the floor of the scaled product is the arithmetic right shift,
  // and only its low bits reach the result since it lies between the entries.
  // --------------------------------------------------------------------------
  logic                 x_valid_q;
  logic                 x_clip_q;
  logic [SW-1:0]        x_base_q;
  logic signed [MW-1:0] x_prod_q;
  logic [SW-1:0]        x_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
    end else begin
      x_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_clip_q <= r_clip_q;
    x_base_q <= rd_a_q;
    x_prod_q <= product;
  end

  assign x_result = x_base_q + x_prod_q[FB +: SW];

  // --------------------------------------------------------------------------
  // Result queue.
  // --------------------------------------------------------------------------
  logic [SW:0]  queue_head;
  fifo_status_t queue_status;

  itws_result_fifo #(
    .Width (SW + 1),
    .Depth (Depth)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (x_valid_q),
    .push_data_i ({x_clip_q, x_result}),
    .pop_i       (out_xfer),
    .pop_data_o  (queue_head),
    .status_o    (queue_status)
  );

  assign out_o.valid         = !queue_status.empty;
  assign out_o.shaped_sample = $signed(queue_head[SW-1:0]);
  assign out_o.clipped       = queue_head[SW];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_inflight_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni) inflight_q <= CntWidth'(Depth)
  ) else $error("more shape requests in flight than the result queue holds");

  a_no_push_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) x_valid_q |-> !queue_status.full
  ) else $error("result arrived at a full result queue");

  a_clip_no_blend : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (x_valid_q && x_clip_q) |-> (x_prod_q == '0)
  ) else $error("clipped sample was blended with a neighbouring entry");

  a_result_counted : assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_o.valid |-> (inflight_q != '0)
  ) else $error("result offered without a shape request in flight");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Interpolated table waveshaper testbench
// Loads the whole transfer table, walks a short table of directed requests
// and then a long random mix of shape and write requests through the unit.
// Results are checked against a typed-in value or a cycle-free shaper predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itws_pkg::*;

  localparam int unsigned TS = INTERVALS_DEF;
  localparam int unsigned SW = SAMPLE_WIDTH_DEF;
  localparam int unsigned FB = FRACTION_BITS_DEF;
  localparam int unsigned IW = $clog2(TS + 1);

  // One half in sample units: the lower and upper edges of the table span.
  localparam int HALF = 1 << (FB - 1);

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

  localparam int RANDOM_ITEMS = 415;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  // One request as the sender offers it. For directed rows whose result is
  // obvious, the expected result is typed in and used instead of the
  // predictor's answer.
  typedef struct packed {
    req_type_e             kind;
    logic signed [SW-1:0]  sample;
    logic        [IW-1:0]  index;
    logic signed [SW-1:0]  value;
    logic                  typed;
    logic signed [SW-1:0]  want_sample;
    logic                  want_clip;
  } shaper_req_t;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 clip;
  } shaped_result_t;

  localparam int NDIR = 22;

  // Directed requests. They run after every entry has been loaded at random,
  // so each read here sees a written entry.
  localparam shaper_req_t DIRECTED [NDIR] = '{
    // End entries set to the extremes of the sample range.
    '{ReqWrite, '0, 10'd0,   S_MIN, 1'b0, '0, 1'b0},
    '{ReqWrite, '0, 10'd512, S_MAX, 1'b0, '0, 1'b0},
    // Extreme inputs clip to the end entries.
    '{ReqShape, S_MIN, '0, '0, 1'b1, S_MIN, 1'b1},
    '{ReqShape, S_MAX, '0, '0, 1'b1, S_MAX, 1'b1},
    // Exactly on the lower edge: entry 0, not clipped.
    '{ReqShape, SW'(-HALF), '0, '0, 1'b1, S_MIN, 1'b0},
    // One step below the lower edge: clipped.
    '{ReqShape, SW'(-HALF - 1), '0, '0, 1'b1, S_MIN, 1'b1},
    // Exactly on the upper edge: the index reaches the table size, clipped.
    '{ReqShape, SW'(HALF), '0, '0, 1'b1, S_MAX, 1'b1},
    // Just below the upper edge: last interval, largest fraction.
    '{ReqShape, SW'(HALF - 1), '0, '0, 1'b0, '0, 1'b0},
    '{ReqWrite, '0, 10'd511, S_MIN, 1'b0, '0, 1'b0},
    '{ReqShape, SW'(HALF - 1), '0, '0, 1'b0, '0, 1'b0},
    // Largest rising step, sampled half way along the first interval.
    '{ReqWrite, '0, 10'd1, S_MAX, 1'b0, '0, 1'b0},
    '{ReqShape, SW'(-HALF + 1024), '0, '0, 1'b0, '0, 1'b0},
    // Largest falling step, smallest fraction: rounding toward minus infinity.
    '{ReqWrite, '0, 10'd1, S_MIN, 1'b0, '0, 1'b0},
    '{ReqWrite, '0, 10'd0, S_MAX, 1'b0, '0, 1'b0},
    '{ReqShape, SW'(-HALF + 1), '0, '0, 1'b0, '0, 1'b0},
    // Writes beyond the table are dropped, so entry 512 keeps its value.
    '{ReqWrite, '0, 10'd513,  24'sd5, 1'b0, '0, 1'b0},
    '{ReqWrite, '0, 10'd1023, 24'sd0, 1'b0, '0, 1'b0},
    '{ReqShape, SW'(HALF), '0, '0, 1'b1, S_MAX, 1'b1},
    // Zero input lands on the centre entry with no fraction.
    '{ReqWrite, '0, 10'd256, 24'sd0, 1'b0, '0, 1'b0},
    '{ReqShape, 24'sd0, '0, '0, 1'b1, 24'sd0, 1'b0},
    // A write to entry 100, then a sample in its interval with a tiny fraction.
    '{ReqWrite, '0, 10'd100, -24'sd1, 1'b0, '0, 1'b0},
    '{ReqShape, SW'(-HALF + 100 * 2048 + 5), '0, '0, 1'b0, '0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  itws_in_if  #(.SampleWidth(SW), .IndexWidth(IW)) in_ch ();
  itws_out_if #(.SampleWidth(SW))                  out_ch ();

  interpolated_table_waveshaper_unit #(
    .INTERVALS     (TS),
    .SAMPLE_WIDTH  (SW),
    .FRACTION_BITS (FB)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: our own copy of the transfer table.
  logic signed [SW-1:0] wave_table [0:TS];

  shaper_req_t    stim_q[$];
  shaped_result_t shaped_expect_q[$];

  int send_idx   = 0;
  int result_cnt = 0;
  int err_cnt    = 0;
  int hold_cnt   = 0;
  bit hold_done  = 1'b0;
  int cycle_cnt  = 0;

  // Linear interpolation through the table. The shifted sample is scaled by
  // the table size; its integer part picks the interval and the fraction
  // bits blend the two neighbouring entries, floored toward minus infinity.
  function automatic shaped_result_t shape_predict(logic signed [SW-1:0] s);
    shaped_result_t y;
    longint shifted, pos, idx, frac, a, b, res;
    shifted = longint'(s) + longint'(HALF);
    y.clip  = 1'b0;
    if (shifted < 0) begin
      res    = longint'(wave_table[0]);
      y.clip = 1'b1;
    end else begin
      pos  = shifted * longint'(TS);
      idx  = pos >>> FB;
      frac = pos & ((longint'(1) << FB) - 1);
      if (idx >= longint'(TS)) begin
        res    = longint'(wave_table[TS]);
        y.clip = 1'b1;
      end else begin
        a   = longint'(wave_table[idx]);
        b   = longint'(wave_table[idx + 1]);
        res = a + (((b - a) * frac) >>> FB);
      end
    end
    y.sample = res[SW-1:0];
    return y;
  endfunction

  // Called once per accepted request transfer, in transfer order.
  function automatic void record_transfer(shaper_req_t r);
    shaped_result_t y;
    if (r.kind == ReqWrite) begin
      if (r.index <= TS) wave_table[r.index] = r.value;
    end else begin
      y = shape_predict(r.sample);
      if (r.typed) begin
        y.sample = r.want_sample;
        y.clip   = r.want_clip;
      end
      shaped_expect_q.push_back(y);
    end
  endfunction

  // Sender: offers requests in order and idles at random, except for a long
  // stretch of back-to-back offers. Valid gets a single assignment per edge,
  // so it stays high across consecutive transfers.
  always @(posedge clk_i) begin
    bit v_next;
    if (rst_ni) begin
      v_next = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        record_transfer(stim_q[send_idx]);
        send_idx++;
        v_next = 1'b0;
      end
      if (!v_next && send_idx < stim_q.size()) begin
        if ((send_idx >= 600 && send_idx < 750) || $urandom_range(99, 0) >= 30) begin
          in_ch.req_type    <= stim_q[send_idx].kind;
          in_ch.sample_in   <= stim_q[send_idx].sample;
          in_ch.entry_index <= stim_q[send_idx].index;
          in_ch.entry_value <= stim_q[send_idx].value;
          v_next = 1'b1;
        end
      end
      in_ch.valid <= v_next;
    end
  end

  // Receiver: checks each result transfer against the oldest expectation.
  // Once, early in the run, it holds ready low for a long stretch so that
  // the result queue fills up and the unit stalls its input.
  always @(posedge clk_i) begin
    bit             r_next;
    shaped_result_t exp_res;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        result_cnt++;
        if (shaped_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected: actual sample %0d clipped %0b",
                   $realtime, out_ch.shaped_sample, out_ch.clipped);
          err_cnt++;
        end else begin
          exp_res = shaped_expect_q.pop_front();
          if (out_ch.shaped_sample !== exp_res.sample) begin
            $display("%0t: shaped_sample mismatch: expected %0d actual %0d",
                     $realtime, exp_res.sample, out_ch.shaped_sample);
            err_cnt++;
          end
          if (out_ch.clipped !== exp_res.clip) begin
            $display("%0t: clipped mismatch: expected %0b actual %0b",
                     $realtime, exp_res.clip, out_ch.clipped);
            err_cnt++;
          end
        end
      end
      if (!hold_done && result_cnt >= 120) begin
        hold_cnt  = 150;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        r_next = 1'b0;
      end else if (result_cnt >= 160 && result_cnt < 260) begin
        r_next = 1'b1;
      end else begin
        r_next = ($urandom_range(99, 0) >= 30);
      end
      out_ch.ready <= r_next;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $realtime, CYCLE_LIMIT);
      $display("** interpolated_table_waveshaper_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    shaper_req_t r;
    logic [31:0] rnd_a, rnd_b, rnd_c;
    int          pick;

    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = ReqShape;
    in_ch.sample_in   = '0;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    out_ch.ready      = 1'b0;

    // The table holds unknown values after reset, so every entry is loaded
    // before the first shape request.
    for (int k = 0; k <= TS; k++) begin
      rnd_a   = $urandom();
      r       = '0;
      r.kind  = ReqWrite;
      r.index = IW'(k);
      r.value = rnd_a[SW-1:0];
      stim_q.push_back(r);
    end

    foreach (DIRECTED[k]) stim_q.push_back(DIRECTED[k]);

    // Random mix: mostly shapes, with writes interleaved so that results
    // keep depending on recently changed entries. Unused fields carry noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      rnd_a    = $urandom();
      rnd_b    = $urandom();
      rnd_c    = $urandom();
      r        = '0;
      r.sample = rnd_a[SW-1:0];
      r.index  = rnd_b[IW-1:0];
      r.value  = rnd_c[SW-1:0];
      if ($urandom_range(99, 0) < 30) begin
        r.kind = ReqWrite;
        if ($urandom_range(99, 0) < 90) r.index = IW'($urandom_range(TS, 0));
        else r.index = IW'($urandom_range((1 << IW) - 1, TS + 1));
        // Small values give small steps, where the rounding shows.
        if ($urandom_range(1, 0) == 0) r.value = SW'($signed(rnd_c[12:0]));
      end else begin
        r.kind = ReqShape;
        pick   = $urandom_range(99, 0);
        if (pick < 60) begin
          r.sample = SW'(-HALF + int'($urandom_range(2 * HALF - 1, 0)));
        end else if (pick < 80) begin
          // Close to either edge of the span.
          if (rnd_b[31]) r.sample = SW'(HALF + int'($urandom_range(16, 0)) - 8);
          else r.sample = SW'(-HALF + int'($urandom_range(16, 0)) - 8);
        end
      end
      stim_q.push_back(r);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (send_idx < stim_q.size() || shaped_expect_q.size() != 0) @(posedge clk_i);
    // Any stray result after the last expected one is caught by the receiver.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("** interpolated_table_waveshaper_unit: PASSED **");
    end else begin
      $display("** interpolated_table_waveshaper_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
rtl/itws_pkg.sv
rtl/itws_if.sv
rtl/itws_result_fifo.sv
rtl/interpolated_table_waveshaper_unit.sv
tb/sv/tb.sv
